// File: sv/pgli_pkg.sv
// Package: shared types, the log2 and exp2 fraction tables and the log helper.
package pgli_pkg;

  localparam int GapDepthDefault = 63;
  localparam int F0_W   = 16;
  localparam int CNT_W  = 6;
  localparam int LG_W   = 20;
  localparam int DIFF_W = LG_W + 1;
  localparam int K_W    = CNT_W;
  localparam int PROD_W = LG_W + K_W;
  localparam int DIV_W  = CNT_W + 1;
  localparam int BIT_W  = 5;
  localparam int EXP_W  = 17;

  typedef enum logic [1:0] {
    KIND_GAP,
    KIND_GAP_END,
    KIND_ANCHOR
  } kind_e;

  typedef struct packed {
    logic [F0_W-1:0] f0;
    kind_e           kind;
    logic            send;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_DATA,
    ST_MUL,
    ST_DIV,
    ST_ADD,
    ST_EXP,
    ST_EMIT,
    ST_FINAL
  } seq_e;

  typedef logic [15:0]      log_tab_t [256];
  typedef logic [EXP_W-1:0] exp_tab_t [256];

  // Fraction of log2 of a Q30 mantissa in [1,2), by repeated squaring.
  function automatic logic [15:0] frac_log2(logic [63:0] m_in);
    logic [63:0] m;
    logic [15:0] r;
    m = m_in;
    r = '0;
    for (int b = 15; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        r[b] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic log_tab_t build_log();
    log_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = frac_log2(64'(256 + i) << 22);
    end
    return t;
  endfunction

  // Largest Q16 mantissa whose log fraction does not exceed i/256.
  function automatic exp_tab_t build_exp();
    exp_tab_t    t;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] lim;
    for (int i = 0; i < 256; i++) begin
      lo  = 64'd65536;
      hi  = 64'd131071;
      lim = 64'(i) << 8;
      while (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        if (64'(frac_log2(mid << 14)) <= lim) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
      t[i] = lo[EXP_W-1:0];
    end
    return t;
  endfunction

  localparam log_tab_t LOG_TAB = build_log();
  localparam exp_tab_t EXP_TAB = build_exp();

  // Q16 log2 of a pitch value; zero counts as one.
  function automatic logic [LG_W-1:0] lg(logic [F0_W-1:0] x_in);
    logic [F0_W-1:0] x;
    logic [3:0]      e;
    logic [F0_W-1:0] m;
    x = (x_in == '0) ? F0_W'(1) : x_in;
    e = '0;
    for (int b = 0; b < F0_W; b++) begin
      if (x[b]) begin
        e = 4'(b);
      end
    end
    m = x << (4'd15 - e);
    return {e, LOG_TAB[m[14:7]]};
  endfunction

endpackage

// File: sv/pgli_ram.sv
// Generic single-port-write, registered-read RAM.
module pgli_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 63,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/pgli_front.sv
// Front end: accepts frames, classifies them and queues them for the back end.
module pgli_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  logic [15:0]            f0_value_i,
  input  logic                   gap_i,
  input  logic                   slice_end_i,
  output pgli_pkg::item_t        item_o,
  output logic                   item_valid_o,
  input  logic                   item_take_i
);
  import pgli_pkg::*;

  item_t      buf_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;
  item_t      in_item;

  always_comb begin
    in_item.f0   = f0_value_i;
    in_item.send = slice_end_i;
    if (!gap_i) begin
      in_item.kind = KIND_ANCHOR;
    end else if (slice_end_i) begin
      in_item.kind = KIND_GAP_END;
    end else begin
      in_item.kind = KIND_GAP;
    end
  end

  assign full         = (cnt_q == 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = buf_q[rptr_q];
  assign do_push      = push && !full;
  assign do_pop       = item_take_i && item_valid_o;

  always_comb begin
    wptr_d = do_push ? ~wptr_q : wptr_q;
    rptr_d = do_pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wptr_q] <= in_item;
    end
  end

endmodule

// File: sv/pgli_back.sv
// Back end: holds gap runs, resolves them and drives the result register.
module pgli_back #(
  parameter int GAP_DEPTH = pgli_pkg::GapDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pgli_pkg::item_t item_i,
  input  logic            item_valid_i,
  output logic            item_take_o,
  output logic            empty,
  input  logic            pop,
  output logic [15:0]     f0_out_o,
  output logic            gap_out_o,
  output logic            overflow_o,
  output logic            run_last_o,
  output logic            slice_last_o
);
  import pgli_pkg::*;

  localparam int AW = (GAP_DEPTH > 1) ? $clog2(GAP_DEPTH) : 1;

  seq_e st_q, st_d;
  item_t cur_q, cur_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, idx_q, idx_d;
  logic [F0_W-1:0] anc_q, anc_d, val_q, val_d;
  logic seen_q, seen_d, ovf_q, ovf_d, subst_q, subst_d;
  logic interp_q, interp_d, useram_q, useram_d;
  logic [LG_W-1:0] la_q, la_d, l_q, l_d;
  logic signed [DIFF_W-1:0] diff_q, diff_d;
  logic [PROD_W-1:0] quo_q, quo_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [BIT_W-1:0] bit_q, bit_d;

  logic ovalid_q, ovalid_d;
  logic [F0_W-1:0] of0_q, of0_d;
  logic og_q, og_d, oo_q, oo_d, orl_q, orl_d, osl_q, osl_d;

  logic we;
  logic [F0_W-1:0] rdata;
  logic slot_free;

  // Combinational helpers.
  logic [LG_W-1:0] mag;
  logic [DIV_W-1:0] dvs;
  logic [DIV_W:0] trial;
  logic signed [DIFF_W+1:0] lsum;
  logic [31:0] shifted;
  logic [EXP_W-1:0] expv;

  pgli_ram #(.WIDTH(F0_W), .DEPTH(GAP_DEPTH)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(cnt_q[AW-1:0]),
    .wdata_i(item_i.f0),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(rdata)
  );

  assign slot_free = !ovalid_q || pop;
  assign empty        = !ovalid_q;
  assign f0_out_o     = of0_q;
  assign gap_out_o    = og_q;
  assign overflow_o   = oo_q;
  assign run_last_o   = orl_q;
  assign slice_last_o = osl_q;

  always_comb begin
    mag   = diff_q[DIFF_W-1] ? LG_W'(-diff_q) : LG_W'(diff_q);
    dvs   = DIV_W'(cnt_q) + DIV_W'(1);
    trial = {rem_q, quo_q[PROD_W-1]};
    lsum  = diff_q[DIFF_W-1] ? ((DIFF_W+2)'(la_q) - (DIFF_W+2)'(quo_q[LG_W-1:0]))
                             : ((DIFF_W+2)'(la_q) + (DIFF_W+2)'(quo_q[LG_W-1:0]));
    expv    = EXP_TAB[l_q[15:8]];
    shifted = 32'(expv) << l_q[19:16];
  end

  always_comb begin
    st_d = st_q; cur_d = cur_q; cnt_d = cnt_q; idx_d = idx_q;
    anc_d = anc_q; val_d = val_q; seen_d = seen_q; ovf_d = ovf_q;
    subst_d = subst_q; interp_d = interp_q; useram_d = useram_q;
    la_d = la_q; l_d = l_q; diff_d = diff_q; quo_d = quo_q;
    rem_d = rem_q; bit_d = bit_q;
    ovalid_d = ovalid_q && !pop;
    of0_d = of0_q; og_d = og_q; oo_d = oo_q; orl_d = orl_q; osl_d = osl_q;
    item_take_o = 1'b0;
    we = 1'b0;

    case (st_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_take_o = 1'b1;
          cur_d    = item_i;
          idx_d    = '0;
          ovf_d    = 1'b0;
          subst_d  = 1'b0;
          interp_d = 1'b0;
          useram_d = 1'b0;
          case (item_i.kind)
            KIND_ANCHOR: begin
              interp_d = seen_q;
              la_d     = lg(anc_q);
              diff_d   = DIFF_W'(lg(item_i.f0)) - DIFF_W'(lg(anc_q));
              val_d    = item_i.f0;
              if (cnt_q == '0) begin
                st_d = ST_FINAL;
              end else if (seen_q) begin
                st_d = ST_MUL;
              end else begin
                st_d = ST_EMIT;
              end
            end
            KIND_GAP, KIND_GAP_END: begin
              if (32'(cnt_q) >= GAP_DEPTH) begin
                ovf_d    = 1'b1;
                useram_d = 1'b1;
                st_d     = ST_RD;
              end else if (item_i.kind == KIND_GAP_END) begin
                subst_d  = seen_q;
                useram_d = 1'b1;
                st_d     = (cnt_q == '0) ? ST_FINAL : ST_RD;
              end else begin
                we    = 1'b1;
                cnt_d = cnt_q + CNT_W'(1);
              end
            end
            default: st_d = ST_IDLE;
          endcase
        end
      end
      ST_RD: st_d = ST_DATA;
      ST_DATA: begin
        val_d = subst_q ? anc_q : rdata;
        st_d  = ST_EMIT;
      end
      ST_MUL: begin
        quo_d = PROD_W'(mag) * PROD_W'(idx_q + CNT_W'(1));
        rem_d = '0;
        bit_d = '0;
        st_d  = ST_DIV;
      end
      ST_DIV: begin
        if (trial >= {1'b0, dvs}) begin
          rem_d = DIV_W'(trial - {1'b0, dvs});
          quo_d = {quo_q[PROD_W-2:0], 1'b1};
        end else begin
          rem_d = trial[DIV_W-1:0];
          quo_d = {quo_q[PROD_W-2:0], 1'b0};
        end
        bit_d = bit_q + BIT_W'(1);
        if (bit_q == BIT_W'(PROD_W - 1)) begin
          st_d = ST_ADD;
        end
      end
      ST_ADD: begin
        if (lsum < 0) begin
          l_d = '0;
        end else if (lsum >= (DIFF_W+2)'(1 << LG_W)) begin
          l_d = '1;
        end else begin
          l_d = lsum[LG_W-1:0];
        end
        st_d = ST_EXP;
      end
      ST_EXP: begin
        val_d = (shifted[31:16] != '0) ? shifted[31:16] : shifted[31:16];
        st_d  = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          of0_d = val_q; og_d = 1'b1; oo_d = ovf_q; orl_d = 1'b0; osl_d = 1'b0;
          idx_d = idx_q + CNT_W'(1);
          if (idx_q + CNT_W'(1) == cnt_q) begin
            st_d = ST_FINAL;
          end else if (interp_q) begin
            st_d = ST_MUL;
          end else if (useram_q) begin
            st_d = ST_RD;
          end else begin
            st_d = ST_EMIT;
          end
        end
      end
      ST_FINAL: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          of0_d = (cur_q.kind == KIND_GAP_END && subst_q) ? anc_q : cur_q.f0;
          og_d  = (cur_q.kind != KIND_ANCHOR);
          oo_d  = ovf_q;
          orl_d = 1'b1;
          osl_d = cur_q.send;
          cnt_d = '0;
          if (cur_q.kind == KIND_ANCHOR) begin
            anc_d  = cur_q.f0;
            seen_d = 1'b1;
          end
          if (cur_q.send) begin
            anc_d  = '0;
            seen_d = 1'b0;
          end
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      cnt_q    <= '0;
      anc_q    <= '0;
      seen_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      cnt_q    <= cnt_d;
      anc_q    <= anc_d;
      seen_q   <= seen_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d; idx_q <= idx_d; val_q <= val_d; ovf_q <= ovf_d;
    subst_q <= subst_d; interp_q <= interp_d; useram_q <= useram_d;
    la_q <= la_d; l_q <= l_d; diff_q <= diff_d; quo_q <= quo_d;
    rem_q <= rem_d; bit_q <= bit_d;
    of0_q <= of0_d; og_q <= og_d; oo_q <= oo_d; orl_q <= orl_d; osl_q <= osl_d;
  end

endmodule

// File: sv/pitch_gap_log_interpolator.sv
// Top level of the pitch gap interpolator: front queue and resolving back end.
//
// The block takes pitch frames (a 16-bit f0 in 1/16 Hz, a gap flag and a
// slice-end flag) and returns resolved frames in order. Anchor frames (gap
// low) come out at once; gap frames are held in a run memory of GAP_DEPTH
// words until the next anchor, where they are filled geometrically in the
// log2 domain between the two anchors, or copy the single anchor when the run
// opens the slice. A run still open at slice end copies the last anchor, or
// passes unchanged when the slice had none. A gap frame that finds the run
// memory full flushes the run and itself unchanged with overflow set.
// run_last marks the last word caused by one input, and slice_last the last
// word of a slice. The input side is a two-word queue, so the front accepts
// frames while the back end is busy or while a result word waits on the
// result register. A gap frame that only joins a run is written straight into
// the run memory; an anchor or slice end without held frames goes straight to
// its final word; a held frame that takes the first anchor of a slice goes
// straight to emit; a held frame that is flushed or copied at slice end passes
// through memory read, data and emit; an interpolated frame passes through the
// bit-serial divider, which works one quotient bit of the 26-bit scaled log
// difference per cycle.
module pitch_gap_log_interpolator #(
  parameter int GAP_DEPTH = pgli_pkg::GapDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [15:0] f0_value_i,
  input  logic        gap_i,
  input  logic        slice_end_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] f0_out_o,
  output logic        gap_out_o,
  output logic        overflow_o,
  output logic        run_last_o,
  output logic        slice_last_o
);
  import pgli_pkg::*;

  item_t item;
  logic  item_valid;
  logic  item_take;

  pgli_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .f0_value_i  (f0_value_i),
    .gap_i       (gap_i),
    .slice_end_i (slice_end_i),
    .item_o      (item),
    .item_valid_o(item_valid),
    .item_take_i (item_take)
  );

  pgli_back #(.GAP_DEPTH(GAP_DEPTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .item_valid_i(item_valid),
    .item_take_o (item_take),
    .empty       (empty),
    .pop         (pop),
    .f0_out_o    (f0_out_o),
    .gap_out_o   (gap_out_o),
    .overflow_o  (overflow_o),
    .run_last_o  (run_last_o),
    .slice_last_o(slice_last_o)
  );

endmodule

// File: verif/tb_pitch_gap_log_interpolator.sv
// Self-checking testbench for the pitch gap interpolator: directed table, random slices.
`timescale 1ns / 1ps

module tb_pitch_gap_log_interpolator;

  localparam int GapDepth   = pgli_pkg::GapDepthDefault;
  // Cycles with no word moving on either side before the run is declared hung.
  // The slowest honest stretch is one interpolated frame behind a long receiver
  // stall, so this limit is many times that.
  localparam int StallLimit = 20000;
  // Total frames to send, directed rows included; the last slice may run over.
  localparam int ItemTarget = 235;

  typedef struct {
    logic [15:0] f0;
    logic        gap;
    logic        ovf;
    logic        run_last;
    logic        slice_last;
  } pitch_word_t;

  // A directed row: one input frame and, where it is obvious, the one word it
  // must produce (an anchor with nothing held simply passes through).
  typedef struct {
    logic [15:0] f0;
    logic        gap;
    logic        slice_end;
    bit          typed;
    logic [15:0] typed_f0;
  } frame_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [15:0] f0_value_i;
  logic        gap_i;
  logic        slice_end_i;
  logic        empty;
  logic        pop;
  logic [15:0] f0_out_o;
  logic        gap_out_o;
  logic        overflow_o;
  logic        run_last_o;
  logic        slice_last_o;

  pitch_gap_log_interpolator DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .f0_value_i   (f0_value_i),
    .gap_i        (gap_i),
    .slice_end_i  (slice_end_i),
    .empty        (empty),
    .pop          (pop),
    .f0_out_o     (f0_out_o),
    .gap_out_o    (gap_out_o),
    .overflow_o   (overflow_o),
    .run_last_o   (run_last_o),
    .slice_last_o (slice_last_o)
  );

  // 2 ns clock.
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Our own copy of the fixed-point log and exp fraction tables.
  logic [15:0] log2_frac [256];
  logic [16:0] exp2_mant [256];

  // Model state of the interpolator.
  logic [15:0] run_values [GapDepth];
  int          run_len;
  logic [15:0] prev_anchor;
  bit          have_anchor;

  pitch_word_t expected_words [$];

  int  error_count;
  int  frames_sent;
  int  words_checked;
  int  overflow_words;
  int  filled_words;
  int  idle_cycles;
  bit  stimulus_done;
  bit  send_busy_free;   // send side pushes with no idle gaps while set
  bit  take_busy_free;

  // log2 fraction of a Q30 mantissa in [1,2): square repeatedly, and every
  // time the square reaches 2 we have found a one bit and halve it.
  function automatic logic [15:0] mant_log_frac(longint unsigned mant);
    logic [15:0] bits;
    bits = '0;
    for (int b = 15; b >= 0; b--) begin
      mant = (mant * mant) >> 30;
      if (mant >= (64'd1 << 31)) begin
        mant = mant >> 1;
        bits[b] = 1'b1;
      end
    end
    return bits;
  endfunction

  task automatic fill_tables();
    longint unsigned lo, hi, mid;
    for (int i = 0; i < 256; i++) begin
      log2_frac[i] = mant_log_frac(longint'(256 + i) << 22);
      lo = 65536;
      hi = 131071;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        if (mant_log_frac(mid << 14) <= longint'(i) << 8) lo = mid;
        else hi = mid - 1;
      end
      exp2_mant[i] = lo[16:0];
    end
  endtask

  // Q16 log2 of a pitch; zero is read as one.
  function automatic longint pitch_log2(logic [15:0] x);
    int          lead;
    logic [15:0] norm;
    if (x == 0) x = 16'd1;
    lead = 0;
    for (int b = 0; b < 16; b++) begin
      if (x[b]) lead = b;
    end
    norm = x << (15 - lead);
    return (longint'(lead) << 16) + log2_frac[norm[14:7]];
  endfunction

  // Geometric fill k steps out of d between two anchors.
  function automatic logic [15:0] geo_fill(logic [15:0] a, logic [15:0] b, int k, int d);
    longint          la, lb, lv;
    longint unsigned v;
    la = pitch_log2(a);
    lb = pitch_log2(b);
    lv = la + ((lb - la) * k) / d;   // signed divide truncates toward zero
    if (lv < 0) lv = 0;
    if ((lv >> 16) > 15) lv = (longint'(16) << 16) - 1;
    v = (longint'(exp2_mant[(lv >> 8) & 255]) << (lv >> 16)) >> 16;
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  task automatic queue_word(logic [15:0] f0, logic g, logic ovf);
    pitch_word_t w;
    w.f0 = f0;
    w.gap = g;
    w.ovf = ovf;
    w.run_last = 1'b0;
    w.slice_last = 1'b0;
    expected_words.insert(expected_words.size(), w);
  endtask

  // Advance the model by one accepted frame and queue the words it causes.
  task automatic predict_frame(logic [15:0] f0, logic g, logic se);
    int made;
    made = 0;
    if (g) begin
      if (run_len >= GapDepth) begin
        // Run memory already full: flush everything unchanged, flagged.
        for (int i = 0; i < run_len; i++) begin
          queue_word(run_values[i], 1'b1, 1'b1);
          made++;
        end
        queue_word(f0, 1'b1, 1'b1);
        made++;
        run_len = 0;
      end else begin
        run_values[run_len] = f0;
        run_len++;
        if (se) begin
          // Open run at slice end copies the last anchor, if any.
          for (int i = 0; i < run_len; i++) begin
            queue_word(have_anchor ? prev_anchor : run_values[i], 1'b1, 1'b0);
            made++;
          end
          run_len = 0;
        end
      end
    end else begin
      for (int i = 0; i < run_len; i++) begin
        queue_word(have_anchor ? geo_fill(prev_anchor, f0, i + 1, run_len + 1) : f0,
                   1'b1, 1'b0);
        if (have_anchor) filled_words++;
        made++;
      end
      queue_word(f0, 1'b0, 1'b0);
      made++;
      run_len = 0;
      prev_anchor = f0;
      have_anchor = 1'b1;
    end
    if (se) begin
      run_len = 0;
      prev_anchor = '0;
      have_anchor = 1'b0;
    end
    if (made > 0) begin
      expected_words[$].run_last = 1'b1;
      expected_words[$].slice_last = se;
    end
  endtask

  // Present one frame and hold it until the block takes it. push is only
  // lowered when an idle gap is drawn, so it never toggles within a step.
  task automatic send_frame(logic [15:0] f0, logic g, logic se);
    int wait_cycles;
    wait_cycles = send_busy_free ? 0 : $urandom_range(0, 12);
    if (wait_cycles > 0) begin
      push <= 1'b0;
      repeat (wait_cycles) @(posedge clk_i);
    end
    push        <= 1'b1;
    f0_value_i  <= f0;
    gap_i       <= g;
    slice_end_i <= se;
    do @(posedge clk_i); while (full);
    predict_frame(f0, g, se);
    frames_sent++;
  endtask

  // Random pitch with a bias toward the extremes and small values.
  function automatic logic [15:0] rand_pitch();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(1, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  // Directed rows: extremes, leading gaps, fills, trailing gaps, anchorless slice.
  frame_row_t directed_rows [] = '{
    '{16'h0000, 1'b0, 1'b0, 1'b1, 16'h0000},  // zero anchor passes through
    '{16'h1234, 1'b1, 1'b0, 1'b0, 16'h0000},
    '{16'hFFFF, 1'b1, 1'b0, 1'b0, 16'h0000},  // fill from zero anchor upward
    '{16'hFFFF, 1'b0, 1'b0, 1'b0, 16'h0000},
    '{16'h0000, 1'b1, 1'b0, 1'b0, 16'h0000},
    '{16'h0001, 1'b0, 1'b0, 1'b0, 16'h0000},  // fill downward to one
    '{16'h5555, 1'b1, 1'b1, 1'b0, 16'h0000},  // trailing gap at slice end
    '{16'hAAAA, 1'b1, 1'b0, 1'b0, 16'h0000},  // leading gaps copy first anchor
    '{16'h0F0F, 1'b1, 1'b0, 1'b0, 16'h0000},
    '{16'h0640, 1'b0, 1'b0, 1'b0, 16'h0000},
    '{16'h0C80, 1'b1, 1'b0, 1'b0, 16'h0000},
    '{16'h0000, 1'b1, 1'b0, 1'b0, 16'h0000},
    '{16'h0C80, 1'b0, 1'b1, 1'b0, 16'h0000},  // anchor ends the slice
    '{16'h7FFF, 1'b1, 1'b0, 1'b0, 16'h0000},  // slice without any anchor
    '{16'h8000, 1'b1, 1'b1, 1'b0, 16'h0000},
    '{16'h0123, 1'b0, 1'b1, 1'b1, 16'h0123},  // single-frame slice
    '{16'hFFFF, 1'b1, 1'b1, 1'b0, 16'h0000}   // lone gap slice
  };

  // Stimulus: directed table first, then random slices.
  initial begin
    int run_gaps;
    int slice_frames;
    int gap_pct;
    pitch_word_t typed_word;
    rst_ni = 1'b0;
    push = 1'b0;
    f0_value_i = '0;
    gap_i = 1'b0;
    slice_end_i = 1'b0;
    run_len = 0;
    prev_anchor = '0;
    have_anchor = 1'b0;
    error_count = 0;
    frames_sent = 0;
    overflow_words = 0;
    filled_words = 0;
    stimulus_done = 1'b0;
    send_busy_free = 1'b0;
    fill_tables();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      send_frame(directed_rows[r].f0, directed_rows[r].gap, directed_rows[r].slice_end);
      if (directed_rows[r].typed) begin
        // Replace the prediction with the value read straight off the row.
        typed_word = expected_words[$];
        typed_word.f0 = directed_rows[r].typed_f0;
        expected_words[$] = typed_word;
      end
    end

    // Random slices. Most are well formed: anchors with gap runs between.
    // A few carry a run long enough to overflow the run memory.
    while (frames_sent < ItemTarget) begin
      send_busy_free = ($urandom_range(0, 3) == 0);
      slice_frames = $urandom_range(1, 24);
      gap_pct = $urandom_range(0, 4) == 0 ? 100 : $urandom_range(10, 70);
      if ($urandom_range(0, 9) == 0) begin
        run_gaps = $urandom_range(GapDepth - 1, GapDepth + 8);
        send_busy_free = 1'b1;
        if ($urandom_range(0, 1)) send_frame(rand_pitch(), 1'b0, 1'b0);
        for (int i = 0; i < run_gaps; i++) send_frame(rand_pitch(), 1'b1, 1'b0);
      end
      for (int i = 0; i < slice_frames; i++) begin
        send_frame(rand_pitch(), ($urandom_range(1, 100) <= gap_pct),
                   (i == slice_frames - 1));
      end
    end
    push <= 1'b0;
    stimulus_done = 1'b1;
  end

  // Result side: pop with random stalls and compare every word in order.
  initial begin
    int          wait_cycles;
    pitch_word_t want;
    pop = 1'b0;
    words_checked = 0;
    take_busy_free = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ((words_checked % 40) == 0) take_busy_free = ($urandom_range(0, 2) == 0);
      wait_cycles = take_busy_free ? 0 : $urandom_range(0, 12);
      if (wait_cycles > 0) begin
        pop <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      words_checked++;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word f0=%h gap=%b ovf=%b", $time, f0_out_o,
                 gap_out_o, overflow_o);
        error_count++;
      end else begin
        want = expected_words.pop_front();
        if (want.ovf) overflow_words++;
        if (f0_out_o !== want.f0) begin
          $display("%0t: f0 expected %h actual %h", $time, want.f0, f0_out_o);
          error_count++;
        end
        if (gap_out_o !== want.gap) begin
          $display("%0t: gap expected %b actual %b", $time, want.gap, gap_out_o);
          error_count++;
        end
        if (overflow_o !== want.ovf) begin
          $display("%0t: overflow expected %b actual %b", $time, want.ovf, overflow_o);
          error_count++;
        end
        if (run_last_o !== want.run_last) begin
          $display("%0t: run_last expected %b actual %b", $time, want.run_last,
                   run_last_o);
          error_count++;
        end
        if (slice_last_o !== want.slice_last) begin
          $display("%0t: slice_last expected %b actual %b", $time, want.slice_last,
                   slice_last_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog: cycles in a row in which no word moves on either side.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("%0t: no progress, %0d words still expected", $time,
                 expected_words.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // End of run: drain, let the block settle, then report.
  initial begin
    wait (stimulus_done);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Sent %0d frames, checked %0d words (%0d interpolated, %0d overflow flushed).",
             frames_sent, words_checked, filled_words, overflow_words);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: pitch_gap_log_interpolator.f
sv/pgli_pkg.sv
sv/pgli_ram.sv
sv/pgli_front.sv
sv/pgli_back.sv
sv/pitch_gap_log_interpolator.sv
verif/tb_pitch_gap_log_interpolator.sv
